### hdl/dbd_pkg.sv
// dbd_pkg: shared widths, controller states, command/status structs and
// month tables for the days-between-dates block
// no dependencies
package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int DOY_W   = 9;
    localparam int M100_W  = 7;
    localparam int M400_W  = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MAX     = YEAR_W'(9999);
    localparam logic [COUNT_W-1:0] DAYS_IN_YEAR = COUNT_W'(365);
    localparam logic [M100_W-1:0]  CENTURY_LAST = M100_W'(99);
    localparam logic [M400_W-1:0]  CYCLE_LAST   = M400_W'(399);
    localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOP,
        ST_SUM,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic years_ok;
        logic loop_last;
        logic out_free;
    } ctrl_stat_t;

    // length of a month in a common year, zero for codes that are no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
            4'd2:                                      len = DAY_W'(28);
            default:                                   len = '0;
        endcase
        return len;
    endfunction

    // days before the first of the month in a common year
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] cum;
        unique case (m)
            4'd1:    cum = DOY_W'(0);
            4'd2:    cum = DOY_W'(31);
            4'd3:    cum = DOY_W'(59);
            4'd4:    cum = DOY_W'(90);
            4'd5:    cum = DOY_W'(120);
            4'd6:    cum = DOY_W'(151);
            4'd7:    cum = DOY_W'(181);
            4'd8:    cum = DOY_W'(212);
            4'd9:    cum = DOY_W'(243);
            4'd10:   cum = DOY_W'(273);
            4'd11:   cum = DOY_W'(304);
            4'd12:   cum = DOY_W'(334);
            default: cum = '0;
        endcase
        return cum;
    endfunction

endpackage

### hdl/dbd_ctrl.sv
// dbd_ctrl: sequencer for load, year loop, sum and result hand-off
// depends on dbd_pkg
module dbd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dbd_pkg::ctrl_stat_t stat,
    output dbd_pkg::ctrl_cmd_t  cmd
);
    import dbd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (!stat.years_ok)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.loop_last)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/dbd_datapath.sv
// dbd_datapath: input capture, year counter with leap tracking, day-of-year
// sums and the output register
// depends on dbd_pkg
module dbd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dbd_pkg::ctrl_cmd_t           cmd,
    output dbd_pkg::ctrl_stat_t          stat,
    input  logic [dbd_pkg::YEAR_W-1:0]   first_year,
    input  logic [dbd_pkg::MONTH_W-1:0]  first_month,
    input  logic [dbd_pkg::DAY_W-1:0]    first_day,
    input  logic [dbd_pkg::YEAR_W-1:0]   second_year,
    input  logic [dbd_pkg::MONTH_W-1:0]  second_month,
    input  logic [dbd_pkg::DAY_W-1:0]    second_day,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dbd_pkg::COUNT_W-1:0]  day_count,
    output logic                         dates_valid
);
    import dbd_pkg::*;

    // captured word
    logic [YEAR_W-1:0]  y1_reg, y2_reg;
    logic [MONTH_W-1:0] m1_reg, m2_reg;
    logic [DAY_W-1:0]   d1_reg, d2_reg;

    // year loop
    logic [YEAR_W-1:0]  year_reg;
    logic [M100_W-1:0]  m100_reg;
    logic [M400_W-1:0]  m400_reg;
    logic [COUNT_W-1:0] acc_reg;
    logic [COUNT_W-1:0] a_reg, b_reg;
    logic               leap1_reg, leap2_reg;

    // sums
    logic [COUNT_W-1:0] ta_reg, tb_reg;
    logic               ok_reg;

    // output register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] day_count_reg;
    logic               dates_valid_reg;

    logic               leap_cur;
    logic [YEAR_W-1:0]  year_top;
    logic               y1_ok, y2_ok;
    logic               ok1, ok2;
    logic [DAY_W:0]     lim1, lim2;
    logic [DOY_W-1:0]   doy1, doy2;
    logic [COUNT_W-1:0] diff;

    assign leap_cur = ((year_reg[1:0] == 2'd0) && (m100_reg != '0)) || (m400_reg == '0);
    assign year_top = (y1_reg > y2_reg) ? y1_reg : y2_reg;
    assign y1_ok    = (y1_reg != '0) && (y1_reg <= YEAR_MAX);
    assign y2_ok    = (y2_reg != '0) && (y2_reg <= YEAR_MAX);

    assign stat.years_ok  = y1_ok && y2_ok;
    assign stat.loop_last = (year_reg == year_top);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // february gets its leap day in a leap year
    assign lim1 = {1'b0, month_len(m1_reg)} +
                  (DAY_W+1)'((m1_reg == MONTH_FEB) && leap1_reg);
    assign lim2 = {1'b0, month_len(m2_reg)} +
                  (DAY_W+1)'((m2_reg == MONTH_FEB) && leap2_reg);

    assign ok1 = (m1_reg != '0) && (m1_reg <= MONTH_DEC) && (d1_reg != '0) &&
                 ({1'b0, d1_reg} <= lim1);
    assign ok2 = (m2_reg != '0) && (m2_reg <= MONTH_DEC) && (d2_reg != '0) &&
                 ({1'b0, d2_reg} <= lim2);

    // leap day counts only after february
    assign doy1 = days_before_month(m1_reg) + DOY_W'(d1_reg) +
                  DOY_W'((m1_reg > MONTH_FEB) && leap1_reg);
    assign doy2 = days_before_month(m2_reg) + DOY_W'(d2_reg) +
                  DOY_W'((m2_reg > MONTH_FEB) && leap2_reg);

    assign diff = (ta_reg > tb_reg) ? (ta_reg - tb_reg) : (tb_reg - ta_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y1_reg   <= first_year;
            m1_reg   <= first_month;
            d1_reg   <= first_day;
            y2_reg   <= second_year;
            m2_reg   <= second_month;
            d2_reg   <= second_day;
            year_reg <= YEAR_W'(1);
            m100_reg <= M100_W'(1);
            m400_reg <= M400_W'(1);
            acc_reg  <= '0;
        end
        else if (cmd.step)
        begin
            if (year_reg == y1_reg)
            begin
                a_reg     <= acc_reg;
                leap1_reg <= leap_cur;
            end
            if (year_reg == y2_reg)
            begin
                b_reg     <= acc_reg;
                leap2_reg <= leap_cur;
            end
            year_reg <= year_reg + YEAR_W'(1);
            m100_reg <= (m100_reg == CENTURY_LAST) ? '0 : m100_reg + M100_W'(1);
            m400_reg <= (m400_reg == CYCLE_LAST) ? '0 : m400_reg + M400_W'(1);
            acc_reg  <= acc_reg + DAYS_IN_YEAR + COUNT_W'(leap_cur);
        end

        if (cmd.finish)
        begin
            ta_reg <= a_reg + COUNT_W'(doy1);
            tb_reg <= b_reg + COUNT_W'(doy2);
            ok_reg <= stat.years_ok && ok1 && ok2;
        end

        if (cmd.emit)
        begin
            day_count_reg   <= ok_reg ? diff : '0;
            dates_valid_reg <= ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign day_count   = day_count_reg;
    assign dates_valid = dates_valid_reg;

endmodule

### hdl/days_between_dates_top.sv
// sequence per word: load, a year loop from year 1 up to the larger year when both
// years are in range (no loop when either is not), sum, then the result into the output reg
// one word at a time: in_ready returns once the result is in the output register;
// the year loop in the datapath adds one year of 365 or 366 days per cycle
// reset: rst_n asynchronous active low clears the controller and the output valid
// depends on dbd_pkg, dbd_ctrl, dbd_datapath
module days_between_dates_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dbd_pkg::YEAR_W-1:0]   first_year,
    input  logic [dbd_pkg::MONTH_W-1:0]  first_month,
    input  logic [dbd_pkg::DAY_W-1:0]    first_day,
    input  logic [dbd_pkg::YEAR_W-1:0]   second_year,
    input  logic [dbd_pkg::MONTH_W-1:0]  second_month,
    input  logic [dbd_pkg::DAY_W-1:0]    second_day,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dbd_pkg::COUNT_W-1:0]  day_count,
    output logic                         dates_valid
);
    import dbd_pkg::*;

    // commands from the sequencer, status back from the datapath
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencer: idle, walk years, sum day of year, hand result to output reg
    dbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: year counter from year 1 with mod 100 and mod 400 counters for
    // the leap rule, snapshots of days before each date's year, then the sums,
    // the absolute difference and the output register
    dbd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .first_year   (first_year),
        .first_month  (first_month),
        .first_day    (first_day),
        .second_year  (second_year),
        .second_month (second_month),
        .second_day   (second_day),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day_count    (day_count),
        .dates_valid  (dates_valid)
    );

endmodule

### hdl/dbd_checker.sv
// dbd_checker: port-level checks on the days-between-dates top level
// depends on dbd_pkg; bound to days_between_dates_top
module dbd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [dbd_pkg::COUNT_W-1:0]  day_count,
    input logic                         dates_valid
);
    import dbd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(day_count) && $stable(dates_valid))
        else $error("result word changed while stalled");

    // invalid dates give a zero count
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dates_valid |-> day_count == '0)
        else $error("nonzero count for invalid dates");

    // count never exceeds the span of the calendar
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> day_count <= COUNT_W'(3652058))
        else $error("count out of range");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a word while busy");

endmodule

bind days_between_dates_top dbd_checker u_chk (.*);

### tb/days_between_dates_top_tb.sv
// days_between_dates_top_tb: self-checking bench for the days-between-dates block,
// directed date pairs first, then random words under random stalls on both sides
// depends on dbd_pkg and days_between_dates_top
module days_between_dates_top_tb;

    import dbd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    // must cover the slowest word, whose year loop runs up to year 9999, plus the longest receiver stall
    localparam int STALL_LIMIT  = 40000;
    // long enough for two small-year words to finish while the receiver waits
    localparam int HOLD_CYCLES  = 2000;
    localparam int TAIL_CYCLES  = 50;
    localparam int MAX_REPORTS  = 10;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
    } date_t;

    typedef struct packed {
        date_t a;
        date_t b;
    } date_pair_t;

    // one expected result word
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               both_ok;
    } span_t;

    // known marks a row whose result is typed in, otherwise it goes to the predictor
    typedef struct packed {
        date_pair_t pair;
        logic       known;
        span_t      span;
    } dir_row_t;

    // flavors of random word
    typedef enum int {
        GEN_SMALL,
        GEN_WIDE,
        GEN_EDGE,
        GEN_BROKEN,
        GEN_RAW
    } gen_mode_t;

    // directed words: extremes, every invalid case, leap days and date ordering
    localparam int DIR_ROWS_N = 25;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // same earliest date twice
        '{'{'{1, 1, 1}, '{1, 1, 1}}, 1, '{0, 1}},
        // full range in both orders
        '{'{'{9999, 12, 31}, '{1, 1, 1}}, 1, '{3652058, 1}},
        '{'{'{1, 1, 1}, '{9999, 12, 31}}, 1, '{3652058, 1}},
        // across a year boundary
        '{'{'{2000, 12, 31}, '{2001, 1, 1}}, 1, '{1, 1}},
        // month zero and months past december
        '{'{'{2020, 0, 15}, '{2020, 1, 15}}, 1, '{0, 0}},
        '{'{'{2020, 5, 15}, '{2020, 13, 1}}, 1, '{0, 0}},
        '{'{'{2020, 15, 31}, '{2020, 1, 1}}, 1, '{0, 0}},
        // year zero, leap day of a year past the top, all-ones year
        '{'{'{0, 1, 1}, '{1, 1, 1}}, 1, '{0, 0}},
        '{'{'{10000, 2, 29}, '{2000, 2, 29}}, 1, '{0, 0}},
        '{'{'{16383, 12, 31}, '{9999, 1, 1}}, 1, '{0, 0}},
        // day zero and days past the end of the month
        '{'{'{1999, 7, 0}, '{1999, 7, 1}}, 1, '{0, 0}},
        '{'{'{2021, 4, 31}, '{2021, 5, 1}}, 1, '{0, 0}},
        '{'{'{2001, 2, 29}, '{2001, 3, 1}}, 1, '{0, 0}},
        '{'{'{1900, 2, 29}, '{1900, 3, 1}}, 1, '{0, 0}},
        '{'{'{2020, 6, 15}, '{2020, 6, 31}}, 1, '{0, 0}},
        '{'{'{16383, 15, 31}, '{16383, 15, 31}}, 1, '{0, 0}},
        // leap days that exist
        '{'{'{2000, 2, 29}, '{2000, 3, 1}}, 0, '{0, 0}},
        '{'{'{2004, 3, 1}, '{2004, 2, 28}}, 0, '{0, 0}},
        // ordering on month, then on day, within one year
        '{'{'{400, 11, 5}, '{400, 10, 20}}, 0, '{0, 0}},
        '{'{'{1600, 6, 30}, '{1600, 6, 1}}, 0, '{0, 0}},
        '{'{'{100, 1, 31}, '{100, 2, 1}}, 0, '{0, 0}},
        // later year with earlier month
        '{'{'{1999, 12, 31}, '{2000, 1, 1}}, 0, '{0, 0}},
        '{'{'{1, 12, 31}, '{2, 1, 1}}, 0, '{0, 0}},
        // near the top of the year range, top year bit set
        '{'{'{9999, 1, 1}, '{9998, 12, 31}}, 0, '{0, 0}},
        '{'{'{9215, 8, 31}, '{8191, 1, 16}}, 0, '{0, 0}}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] day_count;
    logic               dates_valid;

    // results still owed by the block, oldest first
    span_t       span_q [$];
    int          mismatches   = 0;
    int          words_sent   = 0;
    int          results_seen = 0;
    int          valid_seen   = 0;
    int          invalid_seen = 0;
    int unsigned widest       = 0;
    // no_idle turns off random gaps on both sides
    bit          no_idle      = 1'b0;
    // long receiver holds: requested by the stimulus, served by the receiver
    int          hold_req     = 0;
    int          hold_served  = 0;

    days_between_dates_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_year   (first_year),
        .first_month  (first_month),
        .first_day    (first_day),
        .second_year  (second_year),
        .second_month (second_month),
        .second_day   (second_day),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day_count    (day_count),
        .dates_valid  (dates_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // calendar predictor
    // ---------------------------------------------------------------

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // m must be 1 to 12
    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        int unsigned len;
        len = MONTH_DAYS[m - 1];
        if (m == 2 && is_leap(y))
            len++;
        return len;
    endfunction

    // month range is checked before the length lookup
    function automatic bit calendar_ok(input date_t t);
        if (t.y < 1 || t.y > YEAR_MAX)
            return 1'b0;
        if (t.m < 1 || t.m > 12)
            return 1'b0;
        if (t.d < 1)
            return 1'b0;
        return t.d <= month_length(t.y, t.m);
    endfunction

    // days since the day before jan 1 of year 1
    function automatic int unsigned day_number(input date_t t);
        int unsigned p;
        int unsigned n;
        p = t.y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned i = 1; i < t.m; i++)
            n += MONTH_DAYS[i - 1];
        // leap day only once february is over
        if (t.m > 2 && is_leap(t.y))
            n++;
        return n + t.d;
    endfunction

    function automatic span_t predict_span(input date_pair_t w);
        span_t       s;
        int unsigned na;
        int unsigned nb;
        s = '0;
        if (calendar_ok(w.a) && calendar_ok(w.b))
        begin
            na        = day_number(w.a);
            nb        = day_number(w.b);
            s.count   = COUNT_W'((na > nb) ? na - nb : nb - na);
            s.both_ok = 1'b1;
        end
        return s;
    endfunction

    // ---------------------------------------------------------------
    // random words
    // ---------------------------------------------------------------

    function automatic date_t random_date(input int unsigned lo, input int unsigned hi);
        date_t t;
        t.y = YEAR_W'($urandom_range(lo, hi));
        t.m = MONTH_W'($urandom_range(1, 12));
        t.d = DAY_W'($urandom_range(1, month_length(t.y, t.m)));
        return t;
    endfunction

    // leap days, year ends and century years
    function automatic date_t edge_date();
        date_t t;
        case ($urandom_range(0, 3))
            0: t.y = YEAR_W'(4 * $urandom_range(1, 150));
            1: t.y = YEAR_W'(100 * $urandom_range(1, 6));
            2: t.y = YEAR_W'(400 * $urandom_range(1, 2));
            default: t.y = YEAR_W'($urandom_range(1, 600));
        endcase
        case ($urandom_range(0, 4))
            0:
            begin
                t.m = MONTH_W'(2);
                t.d = DAY_W'(28);
            end
            1:
            begin
                t.m = MONTH_W'(2);
                t.d = DAY_W'(29);
            end
            2:
            begin
                t.m = MONTH_W'(3);
                t.d = DAY_W'(1);
            end
            3:
            begin
                t.m = MONTH_W'(12);
                t.d = DAY_W'(31);
            end
            default:
            begin
                t.m = MONTH_W'(1);
                t.d = DAY_W'(1);
            end
        endcase
        return t;
    endfunction

    function automatic date_pair_t make_pair(input gen_mode_t mode);
        date_pair_t  w;
        date_t       t;
        logic [63:0] bits;
        case (mode)
            // small years keep the year loop short
            GEN_SMALL:
            begin
                w.a = random_date(1, 600);
                w.b = random_date(1, 600);
            end
            GEN_WIDE:
            begin
                w.a = random_date(1, YEAR_MAX);
                w.b = random_date(1, YEAR_MAX);
            end
            GEN_EDGE:
            begin
                w.a = edge_date();
                w.b = edge_date();
                if ($urandom_range(0, 1))
                    w.b.y = w.a.y;
            end
            // one field of one date broken, the rest well formed
            GEN_BROKEN:
            begin
                t = random_date(1, 600);
                case ($urandom_range(0, 6))
                    0: t.m = '0;
                    1: t.m = MONTH_W'($urandom_range(13, 15));
                    2: t.d = '0;
                    3:
                    begin
                        t.m = MONTH_W'(2);
                        t.d = DAY_W'($urandom_range(30, 31));
                    end
                    4:
                    begin
                        t.m = MONTH_W'($urandom_range(0, 1) ? 9 : 11);
                        t.d = DAY_W'(31);
                    end
                    5: t.y = '0;
                    default: t.y = YEAR_W'($urandom_range(10000, 16383));
                endcase
                if ($urandom_range(0, 1))
                begin
                    w.a = t;
                    w.b = random_date(1, 600);
                end
                else
                begin
                    w.a = random_date(1, 600);
                    w.b = t;
                end
            end
            default:
            begin
                bits = {$urandom, $urandom};
                w    = bits[$bits(date_pair_t)-1:0];
            end
        endcase
        return w;
    endfunction

    function automatic gen_mode_t pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return GEN_SMALL;
        if (r < 63)
            return GEN_WIDE;
        if (r < 80)
            return GEN_EDGE;
        if (r < 90)
            return GEN_BROKEN;
        return GEN_RAW;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(40, 150);
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // drive at the falling edge, hold until accepted, then log what the block owes
    task automatic send_pair(input date_pair_t w, input span_t want);
        @(negedge clk);
        in_valid     <= 1'b1;
        first_year   <= w.a.y;
        first_month  <= w.a.m;
        first_day    <= w.a.d;
        second_year  <= w.b.y;
        second_month <= w.b.m;
        second_day   <= w.b.d;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        span_q.push_back(want);
        words_sent++;
    endtask

    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // output side: random stalls, long holds on request
    // ---------------------------------------------------------------

    initial
    begin : receiver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_req)
            begin
                hold_served = hold_req;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // long hold so the block backs up into its input
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 9) < 3)
            begin
                // a short stall most of the time, rarely a long one
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // result check against the oldest owed word
    // ---------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : result_check
        span_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (span_q.size() == 0)
            begin
                note_mismatch($sformatf("result %0d with none owed: day_count %0d dates_valid %0b",
                                        results_seen, day_count, dates_valid));
            end
            else
            begin
                want = span_q.pop_front();
                if (day_count !== want.count)
                    note_mismatch($sformatf("result %0d day_count expected %0d got %0d",
                                            results_seen, want.count, day_count));
                if (dates_valid !== want.both_ok)
                    note_mismatch($sformatf("result %0d dates_valid expected %0b got %0b",
                                            results_seen, want.both_ok, dates_valid));
                if (want.both_ok)
                begin
                    valid_seen++;
                    if (want.count > widest)
                        widest = want.count;
                end
                else
                begin
                    invalid_seen++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: cycles with no word moving on either side
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("timeout: %0d cycles without a word, %0d results owed",
                     quiet, span_q.size());
            $display("days_between_dates_top_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        date_pair_t w;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        first_year   = '0;
        first_month  = '0;
        first_day    = '0;
        second_year  = '0;
        second_month = '0;
        second_day   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, typed-in results where they are obvious
        for (int i = 0; i < DIR_ROWS_N; i++)
        begin
            send_pair(DIR_ROWS[i].pair,
                      DIR_ROWS[i].known ? DIR_ROWS[i].span : predict_span(DIR_ROWS[i].pair));
            idle_sender(sender_gap());
        end
        // sender waits for every result before going on
        drain();

        // first random stretch
        for (int i = 0; i < 25; i++)
        begin
            w = make_pair(pick_mode());
            send_pair(w, predict_span(w));
            idle_sender(sender_gap());
        end

        // receiver holds off while short words keep coming, block backs up
        hold_req++;
        for (int i = 0; i < 8; i++)
        begin
            w = make_pair(GEN_SMALL);
            send_pair(w, predict_span(w));
        end
        drain();

        // stretch with no idling on either side
        no_idle = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            w = make_pair(($urandom_range(0, 1)) ? GEN_SMALL : GEN_EDGE);
            send_pair(w, predict_span(w));
        end
        drain();
        no_idle = 1'b0;

        // last random stretch
        for (int i = 0; i < 25; i++)
        begin
            w = make_pair(pick_mode());
            send_pair(w, predict_span(w));
            idle_sender(sender_gap());
        end

        drain();
        // keep the clock running to catch any stray result
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d words: %0d valid pairs up to %0d days apart, %0d rejected",
                 words_sent, valid_seen, widest, invalid_seen);
        $display("long receiver hold and full drains done, %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("days_between_dates_top_tb: PASS");
        else
            $display("days_between_dates_top_tb: FAIL");
        $finish;
    end

endmodule

### files.f
hdl/dbd_pkg.sv
hdl/dbd_ctrl.sv
hdl/dbd_datapath.sv
hdl/days_between_dates_top.sv
hdl/dbd_checker.sv
tb/days_between_dates_top_tb.sv
